/* hdl/ogtd_pkg.sv */
package ogtd_pkg;

  // sample position counter, saturates at its all-ones value
  localparam int unsigned IDX_W = 10;
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  // window positions reach past the counter range, one extra bit
  localparam int unsigned POS_W = IDX_W + 1;

  // frame geometry
  localparam int unsigned FRAME_BITS = 21;
  localparam int unsigned MIN_FRAME_BITS = 18;
  localparam int unsigned MIN_VALID_COUNT = (FRAME_BITS - 2) * 3;
  localparam int unsigned MAX_VALID_COUNT = (FRAME_BITS + 2) * 3;
  localparam int unsigned SKIP_SAMPLES = 10;

  // bit accumulator only needs the bits that reach the frame
  localparam int unsigned SHIFT_W = FRAME_BITS;
  localparam int unsigned COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned RUN_W = 7;
  localparam int unsigned LEN_W = 5;

  localparam logic [3:0] CHECKSUM_OK = 4'hF;
  localparam int unsigned TELEM_W = 12;

  // apb register map
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PIN_W = 4;

  typedef enum logic [3:0] {
    PH_SEEK = 4'b0001,
    PH_RISE = 4'b0010,
    PH_FALL = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // gcr 5b to 4b: {bad, nibble}
  function automatic logic [4:0] gcr_nibble(input logic [4:0] code);
    logic [4:0] r;
    begin
      case (code)
        5'h09: r = {1'b0, 4'd9};
        5'h0A: r = {1'b0, 4'd10};
        5'h0B: r = {1'b0, 4'd11};
        5'h0D: r = {1'b0, 4'd13};
        5'h0E: r = {1'b0, 4'd14};
        5'h0F: r = {1'b0, 4'd15};
        5'h12: r = {1'b0, 4'd2};
        5'h13: r = {1'b0, 4'd3};
        5'h15: r = {1'b0, 4'd5};
        5'h16: r = {1'b0, 4'd6};
        5'h17: r = {1'b0, 4'd7};
        5'h19: r = {1'b0, 4'd0};
        5'h1A: r = {1'b0, 4'd8};
        5'h1B: r = {1'b0, 4'd1};
        5'h1D: r = {1'b0, 4'd4};
        5'h1E: r = {1'b0, 4'd12};
        default: r = {1'b1, 4'd0};
      endcase
      return r;
    end
  endfunction

  // floor(x / 3) for x below 128, by reciprocal multiply
  function automatic logic [5:0] div3(input logic [RUN_W-1:0] x);
    logic [12:0] p;
    begin
      p = 13'(x) * 13'd43;
      return p[12:7];
    end
  endfunction

endpackage

/* hdl/ogtd_if.sv */
interface ogtd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] port_word;
  logic        last;

  modport source (output valid, output port_word, output last, input ready);
  modport sink (input valid, input port_word, input last, output ready);
endinterface

interface ogtd_out_if;
  logic                              valid;
  logic                              ready;
  logic                              valid_res;
  logic [ogtd_pkg::TELEM_W-1:0]      telemetry;

  modport source (output valid, output valid_res, output telemetry, input ready);
  modport sink (input valid, input valid_res, input telemetry, output ready);
endinterface

/* hdl/oversampled_gcr_telemetry_decoder_top.sv */
// Decodes one bidirectional telemetry reply from a capture buffer of port words taken at
// three times the bit rate. One port word is taken per transaction on in_ch, one per clock
// when nothing stalls; the word marked last closes the buffer and yields one transaction on
// out_ch (valid_res and the 12-bit telemetry, zero when invalid) after the three register
// stages (input, run tracking, frame decode). The run tracker handles one sample per clock
// unless a last word stalls; intake continues while a result waits. pin_select (APB byte
// address 0, bits 3:0) picks the line within the port word and must be written only while
// the block is idle; nothing enforces this. BUFFER_SAMPLES is the capture buffer length.
module oversampled_gcr_telemetry_decoder_top #(
  parameter int unsigned BUFFER_SAMPLES = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ogtd_in_if.sink                            in_ch,
  ogtd_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ogtd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ogtd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ogtd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned SEARCH_LIMIT = BUFFER_SAMPLES - ogtd_pkg::MIN_VALID_COUNT;
  localparam logic [ogtd_pkg::POS_W-1:0] LIMIT_POS = ogtd_pkg::POS_W'(SEARCH_LIMIT);
  localparam logic [ogtd_pkg::POS_W-1:0] SKIP_POS = ogtd_pkg::POS_W'(ogtd_pkg::SKIP_SAMPLES);
  localparam logic [ogtd_pkg::POS_W-1:0] WIN_LEN =
    ogtd_pkg::POS_W'(ogtd_pkg::MAX_VALID_COUNT);

  // configuration register
  logic [ogtd_pkg::PIN_W-1:0] pin_r;
  logic                       cfg_wr;

  // input stage
  logic s1_v_r, s1_high_r, s1_last_r;

  // run tracking state
  ogtd_pkg::phase_t                phase_r, phase_nxt;
  logic [ogtd_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [ogtd_pkg::IDX_W-1:0]      edge_r, edge_nxt;
  logic [ogtd_pkg::POS_W-1:0]      wend_r, wend_nxt;
  logic [ogtd_pkg::SHIFT_W-1:0]    shift_r, shift_nxt;
  logic [ogtd_pkg::COUNT_W-1:0]    count_r, count_nxt;

  // captured frame
  logic                            f_v_r;
  logic [ogtd_pkg::SHIFT_W-1:0]    f_shift_r;
  logic [ogtd_pkg::COUNT_W-1:0]    f_count_r;

  // result register
  logic                            out_v_r, res_ok_r;
  logic [ogtd_pkg::TELEM_W-1:0]    telem_r;

  // flow control
  logic out_free, frame_free, s1_go, f_go, in_go;

  assign out_free   = !out_v_r || out_ch.ready;
  assign f_go       = f_v_r && out_free;
  assign frame_free = !f_v_r || out_free;
  assign s1_go      = s1_v_r && (!s1_last_r || frame_free);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_go      = in_ch.valid && in_ch.ready;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(ogtd_pkg::CFG_DATA_W - ogtd_pkg::PIN_W){1'b0}}, pin_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
    end else if (cfg_wr) begin
      pin_r <= pwdata[ogtd_pkg::PIN_W-1:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_high_r <= in_ch.port_word[pin_r];
      s1_last_r <= in_ch.last;
    end
  end

  // run length and shifted bits for an accepted edge
  logic [ogtd_pkg::POS_W-1:0]   j_pos, j_pos1, run_w;
  logic [5:0]                   len_q;
  logic [ogtd_pkg::LEN_W-1:0]   len;
  logic                         ones;
  logic [ogtd_pkg::SHIFT_W-1:0] shift_taken;
  logic [ogtd_pkg::COUNT_W:0]   count_sum;
  logic                         edge_seen;

  always_comb begin
    j_pos  = {1'b0, idx_r};
    j_pos1 = j_pos + 1'b1;
    run_w  = j_pos - {1'b0, edge_r} + ogtd_pkg::POS_W'(2);
    len_q  = ogtd_pkg::div3(run_w[ogtd_pkg::RUN_W-1:0]);
    len    = (len_q == '0) ? ogtd_pkg::LEN_W'(1) : len_q[ogtd_pkg::LEN_W-1:0];
    ones   = (phase_r == ogtd_pkg::PH_FALL);
    shift_taken = (shift_r << len) |
                  (ones ? ~({ogtd_pkg::SHIFT_W{1'b1}} << len) : '0);
    count_sum = {1'b0, count_r} + (ogtd_pkg::COUNT_W + 1)'(len);
    edge_seen = (phase_r == ogtd_pkg::PH_RISE) ? s1_high_r : !s1_high_r;
  end

  // per-sample state update
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    edge_nxt  = edge_r;
    wend_nxt  = wend_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    if (idx_r != ogtd_pkg::IDX_MAX) begin
      idx_nxt = idx_r + 1'b1;
      case (phase_r)
        ogtd_pkg::PH_SEEK: begin
          if (j_pos >= SKIP_POS && j_pos < LIMIT_POS && !s1_high_r) begin
            if (j_pos1 >= LIMIT_POS) begin
              phase_nxt = ogtd_pkg::PH_DONE;
            end else begin
              edge_nxt  = j_pos1[ogtd_pkg::IDX_W-1:0];
              wend_nxt  = j_pos1 + WIN_LEN;
              phase_nxt = ogtd_pkg::PH_RISE;
            end
          end
        end
        ogtd_pkg::PH_RISE, ogtd_pkg::PH_FALL: begin
          if (j_pos >= wend_r) begin
            phase_nxt = ogtd_pkg::PH_DONE;
          end else if (edge_seen) begin
            if (j_pos1 >= wend_r) begin
              phase_nxt = ogtd_pkg::PH_DONE;
            end else begin
              shift_nxt = shift_taken;
              count_nxt = count_sum[ogtd_pkg::COUNT_W] ? ogtd_pkg::COUNT_MAX :
                          count_sum[ogtd_pkg::COUNT_W-1:0];
              edge_nxt  = j_pos1[ogtd_pkg::IDX_W-1:0];
              phase_nxt = ones ? ogtd_pkg::PH_RISE : ogtd_pkg::PH_FALL;
            end
          end
        end
        ogtd_pkg::PH_DONE: begin
          phase_nxt = ogtd_pkg::PH_DONE;
        end
        default: begin
          phase_nxt = ogtd_pkg::PH_DONE;
        end
      endcase
    end
  end

  // tracking registers, cleared after the buffer's last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ogtd_pkg::PH_SEEK;
      idx_r   <= '0;
      edge_r  <= '0;
      wend_r  <= '0;
      shift_r <= '0;
      count_r <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        phase_r <= ogtd_pkg::PH_SEEK;
        idx_r   <= '0;
        edge_r  <= '0;
        wend_r  <= '0;
        shift_r <= '0;
        count_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        edge_r  <= edge_nxt;
        wend_r  <= wend_nxt;
        shift_r <= shift_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      f_v_r <= 1'b1;
    end else if (f_go) begin
      f_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      f_shift_r <= shift_nxt;
      f_count_r <= count_nxt;
    end
  end

  // frame decode: length check, pad, xor decode, gcr lookup, checksum
  logic                          len_ok;
  logic [1:0]                    fill;
  logic [ogtd_pkg::SHIFT_W-1:0]  padded, gcr_word;
  logic [4:0]                    g0, g1, g2, g3;
  logic [15:0]                   decoded;
  logic                          codes_ok, sum_ok, frame_ok;

  always_comb begin
    len_ok = (f_count_r >= ogtd_pkg::COUNT_W'(ogtd_pkg::MIN_FRAME_BITS)) &&
             (f_count_r <= ogtd_pkg::COUNT_W'(ogtd_pkg::FRAME_BITS));
    fill   = 2'(ogtd_pkg::COUNT_W'(ogtd_pkg::FRAME_BITS) - f_count_r);
    padded = (f_shift_r << fill) | ~({ogtd_pkg::SHIFT_W{1'b1}} << fill);
    gcr_word = padded ^ (padded >> 1);
    g0 = ogtd_pkg::gcr_nibble(gcr_word[4:0]);
    g1 = ogtd_pkg::gcr_nibble(gcr_word[9:5]);
    g2 = ogtd_pkg::gcr_nibble(gcr_word[14:10]);
    g3 = ogtd_pkg::gcr_nibble(gcr_word[19:15]);
    decoded  = {g3[3:0], g2[3:0], g1[3:0], g0[3:0]};
    codes_ok = !(g0[4] || g1[4] || g2[4] || g3[4]);
    sum_ok   = ((decoded[3:0] ^ decoded[7:4] ^ decoded[11:8] ^ decoded[15:12])
                == ogtd_pkg::CHECKSUM_OK);
    frame_ok = len_ok && codes_ok && sum_ok;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_go) begin
      res_ok_r <= frame_ok;
      telem_r  <= frame_ok ? decoded[15:4] : '0;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.valid_res = res_ok_r;
  assign out_ch.telemetry = telem_r;

  // a new result only appears when a captured frame was waiting
  a_out_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(f_v_r))
    else $error("result raised without a captured frame");

  // a stalled frame keeps its contents
  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r && !out_free |=> f_v_r && $stable(f_count_r) && $stable(f_shift_r))
    else $error("captured frame lost while the result stage stalls");

  // closing the buffer restarts the sample counter and the search
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> idx_r == '0 && phase_r == ogtd_pkg::PH_SEEK)
    else $error("tracking state not cleared after the last sample");

  // an invalid frame reports zero telemetry
  a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_ok_r |-> telem_r == '0)
    else $error("nonzero telemetry on an invalid frame");

endmodule
